[hw/rtl/md5_pkg.sv]
// md5_pkg: shared types and constants for the streaming MD5 engine.
// No dependencies.
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   // item handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } md5_item_type;

   // round constant table
   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   // rotate amount per round
   function automatic logic [4:0] round_s(input logic [5:0] r);
      logic [4:0] s;
      begin
         case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
            4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
            4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
            4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

   // message word index per round
   function automatic logic [3:0] round_g(input logic [5:0] r);
      logic [3:0] g;
      logic [3:0] lo;
      begin
         lo = r[3:0];
         case (r[5:4])
            2'd0: g = lo;
            2'd1: g = 4'((5 * lo) + 1);
            2'd2: g = 4'((3 * lo) + 5);
            default: g = 4'(7 * lo);
         endcase
         return g;
      end
   endfunction

endpackage

[hw/rtl/md5_stream_hash.sv]
// md5_stream_hash: top level of the streaming MD5 engine.
// Depends on md5_pkg, md5_front and md5_core.
//
//  channel | direction | contents
//  req_    | in        | tdata: data_byte; tuser: has_byte[0], end_of_message[1]
//  rsp_    | out       | tdata: digest_word; tuser: word_number; tlast: last_word
//
// Bytes are taken one per cycle while the core is idle; each full block then runs
// through the single shared round unit and then the chaining add.
// End of message pads one byte per cycle (up to 64 more, plus a second
// block of 64 padding bytes and 64 rounds when the length does not fit),
// then shows four words.
// Synchronous active-high reset; a four-entry queue lets input run ahead.
module md5_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] has_byte, [1] end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_number
   output logic        rsp_tlast
);
   import md5_pkg::*;

   md5_item_type in_item, q_item;
   logic         q_valid, q_ready;

   assign in_item.data_byte      = req_tdata;
   assign in_item.has_byte       = req_tuser[0];
   assign in_item.end_of_message = req_tuser[1];

   md5_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   md5_core u_core (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(rsp_tdata), .out_number(rsp_tuser), .out_last(rsp_tlast)
   );
endmodule

[hw/rtl/md5_front.sv]
// md5_front: accepts items, drops empty ones, and queues them for the back end.
// Depends on md5_pkg.
module md5_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  md5_pkg::md5_item_type in_item,
   output logic                  q_valid,
   input  logic                  q_ready,
   output md5_pkg::md5_item_type q_item
);
   import md5_pkg::*;

   localparam int DEPTH = 4;

   md5_item_type mem_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push, pop, keep;

   // items with neither byte nor end do nothing and are discarded
   assign keep     = in_item.has_byte | in_item.end_of_message;
   assign in_ready = (count_ff != 3'(DEPTH));
   assign push     = in_valid & in_ready & keep;
   assign q_valid  = (count_ff != 3'd0);
   assign pop      = q_valid & q_ready;
   assign q_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

[hw/rtl/md5_core.sv]
// md5_core: byte gathering, padding, 64-round compression and digest output.
// Depends on md5_pkg.
module md5_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  md5_pkg::md5_item_type q_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           out_word,
   output logic [1:0]            out_number,
   output logic                  out_last
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] words_ff [16];
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] bits_ff, len_ff;
   logic [5:0]  fill_ff, round_ff;
   logic [1:0]  out_idx_ff;
   logic        finishing_ff, pend_end_ff;
   logic        zero_tail_ff;

   logic [31:0] f, sum, rot;
   logic [4:0]  s;
   logic [7:0]  pad_byte;
   logic [5:0]  nxt_fill;

   // round function
   always_comb begin
      case (round_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + round_k(round_ff) + words_ff[round_g(round_ff)];
      s   = round_s(round_ff);
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   // padding byte: 0x80, zeros, then length little endian
   always_comb begin
      if (!finishing_ff) begin
         pad_byte = PAD_BYTE;
      end else if (fill_ff >= LEN_POS && !zero_tail_ff) begin
         pad_byte = len_ff[{fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
      nxt_fill = fill_ff + 6'd1;
   end

   assign q_ready    = (state_ff == ST_IDLE);
   assign out_valid  = (state_ff == ST_OUT);
   assign out_word   = h_ff[out_idx_ff];
   assign out_number = out_idx_ff;
   assign out_last   = (out_idx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff[0]      <= INIT_A;
         h_ff[1]      <= INIT_B;
         h_ff[2]      <= INIT_C;
         h_ff[3]      <= INIT_D;
         bits_ff      <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         finishing_ff <= 1'b0;
         pend_end_ff  <= 1'b0;
         zero_tail_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.has_byte) begin
                     words_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= q_item.data_byte;
                     fill_ff <= nxt_fill;
                     bits_ff <= bits_ff + 64'd8;
                     len_ff  <= bits_ff + 64'd8;
                     pend_end_ff <= q_item.end_of_message;
                     if (nxt_fill == 6'd0) begin
                        round_ff <= '0;
                        a_ff <= h_ff[0]; b_ff <= h_ff[1];
                        c_ff <= h_ff[2]; d_ff <= h_ff[3];
                        state_ff <= ST_ROUND;
                     end else if (q_item.end_of_message) begin
                        state_ff <= ST_PAD;
                     end
                  end else begin
                     len_ff      <= bits_ff;
                     pend_end_ff <= 1'b1;
                     state_ff    <= ST_PAD;
                  end
               end
            end
            // one padding byte per cycle
            ST_PAD: begin
               words_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= pad_byte;
               finishing_ff <= 1'b1;
               fill_ff      <= nxt_fill;
               // 0x80 landed in the length slots: length goes in an extra block
               if (!finishing_ff && fill_ff >= LEN_POS) begin
                  zero_tail_ff <= 1'b1;
               end
               if (nxt_fill == 6'd0) begin
                  round_ff <= '0;
                  a_ff <= h_ff[0]; b_ff <= h_ff[1];
                  c_ff <= h_ff[2]; d_ff <= h_ff[3];
                  state_ff <= ST_ROUND;
               end
            end
            // one compression round per cycle
            ST_ROUND: begin
               a_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= b_ff;
               b_ff <= b_ff + rot;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               zero_tail_ff <= 1'b0;
               // last block of message once length bytes are in
               if (finishing_ff && pend_end_ff && !zero_tail_ff) begin
                  state_ff <= ST_OUT;
               end else if (pend_end_ff) begin
                  state_ff <= ST_PAD;
               end else begin
                  state_ff <= ST_IDLE;
               end
               out_idx_ff <= '0;
            end
            ST_OUT: begin
               if (out_ready) begin
                  out_idx_ff <= out_idx_ff + 2'd1;
                  if (out_idx_ff == 2'd3) begin
                     h_ff[0]      <= INIT_A;
                     h_ff[1]      <= INIT_B;
                     h_ff[2]      <= INIT_C;
                     h_ff[3]      <= INIT_D;
                     bits_ff      <= '0;
                     fill_ff      <= '0;
                     finishing_ff <= 1'b0;
                     pend_end_ff  <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/md5_checker.sv]
// md5_checker: port-level checks on the MD5 engine's result channel.
// Depends on md5_stream_hash (bound to it).
module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   // last word flag matches the word number
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd3)))
      else $error("tlast does not match word number");

   // words of a digest follow in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1))
      else $error("digest words out of order");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled word changed");
endmodule

bind md5_stream_hash md5_checker u_md5_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
